@@ design/bale_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bale_pkg
// Types and constants shared by the bounded list engine, its cells and its
// checker.
// ----------------------------------------------------------------------------
package bale_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned DataW    = 32;
  localparam int unsigned KindW    = 3;
  localparam int unsigned PosW     = 6;
  localparam int unsigned LimitW   = 7;
  localparam int unsigned CountW   = 7;
  localparam int unsigned StatusW  = 2;

  localparam logic [LimitW-1:0] LimitReset = 7'd64;

  typedef enum logic [KindW-1:0] {
    K_INSERT   = 3'd0,
    K_APPEND   = 3'd1,
    K_CONTAINS = 3'd2,
    K_GET      = 3'd3,
    K_REMOVE   = 3'd4,
    K_SET      = 3'd5
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_SET    = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e                 op;
    logic                     look;
    logic signed [DataW-1:0]  value;
  } cell_cmd_t;

  typedef struct packed {
    logic [KindW-1:0]         kind;
    logic [PosW-1:0]          position;
    logic signed [DataW-1:0]  value;
  } req_t;

  typedef struct packed {
    logic signed [DataW-1:0]  read_value;
    logic                     found;
    logic [StatusW-1:0]       status;
    logic [CountW-1:0]        entry_count;
    logic                     is_empty;
    logic                     is_full;
  } rsp_t;

  typedef logic [LimitW-1:0] cfg_t;

endpackage
`default_nettype wire

@@ design/bale_chan_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bale_chan_if
// Valid/ready channel carrying one item of payload type T.
// ----------------------------------------------------------------------------
interface bale_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ design/bale_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bale_cell
// One list entry: shifts from its neighbors, takes a written value and
// compares its entry against a search value.
// ----------------------------------------------------------------------------
module bale_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 7
) (
  input  wire logic                             clk_i,
  input  wire bale_pkg::cell_cmd_t              cmd_i,
  input  wire logic [CNT_W-1:0]                 pos_i,
  input  wire logic [CNT_W-1:0]                 cnt_i,
  input  wire logic signed [bale_pkg::DataW-1:0] left_i,
  input  wire logic signed [bale_pkg::DataW-1:0] right_i,
  output logic signed [bale_pkg::DataW-1:0]      data_o,
  output logic                                   match_o
);

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);

  logic signed [bale_pkg::DataW-1:0] data_q, data_d;
  logic                              match_q, match_d;
  logic                              at_pos, above_pos;

  always_comb begin
    at_pos    = (MyIdx == pos_i);
    above_pos = (MyIdx > pos_i);
    data_d    = data_q;
    case (cmd_i.op)
      bale_pkg::OP_INSERT: begin
        if (above_pos) begin
          data_d = left_i;
        end else if (at_pos) begin
          data_d = cmd_i.value;
        end
      end
      bale_pkg::OP_REMOVE: begin
        if (above_pos || at_pos) begin
          data_d = right_i;
        end
      end
      bale_pkg::OP_SET: begin
        if (at_pos) begin
          data_d = cmd_i.value;
        end
      end
      default: begin
        data_d = data_q;
      end
    endcase
    // hit is held until the next search
    match_d = cmd_i.look ? ((MyIdx < cnt_i) && (data_q == cmd_i.value)) : match_q;
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    match_q <= match_d;
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule
`default_nettype wire

@@ design/bounded_array_list_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_array_list_engine
// Bounded ordered list of signed 32-bit entries, one operation per item.
// ----------------------------------------------------------------------------
// At the accepting edge the row of cells shifts, writes or compares all
// entries at once and the count is updated; in S_DONE the per-cell match
// flags are OR-ed into the result register once that register can be loaded.
// A new item is taken only after S_DONE has loaded its result, even while
// that result still waits in the result register; the engine holds in S_DONE
// only while the result register is occupied and not being taken. The size
// limit is written through the cfg channel, which is always ready.
// ----------------------------------------------------------------------------
module bounded_array_list_engine (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  bale_chan_if.sink       req_i,
  bale_chan_if.source     rsp_o,
  bale_chan_if.sink       cfg_i
);

  localparam int unsigned CAPACITY = bale_pkg::Capacity;
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned ADDR_W = $clog2(CAPACITY);
  localparam int unsigned CMP_W  = (CNT_W > bale_pkg::LimitW) ? CNT_W : bale_pkg::LimitW;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DONE = 2'b10
  } state_e;

  state_e                           state_q, state_d;
  logic [CNT_W-1:0]                 count_q, count_d;
  logic [bale_pkg::LimitW-1:0]      size_limit_q;
  bale_pkg::rsp_t                   pend_q, pend_d;
  bale_pkg::rsp_t                   rsp_q, rsp_d;
  logic                             rsp_valid_q;
  bale_pkg::cell_cmd_t              cmd;
  logic [CNT_W-1:0]                 wr_pos;
  logic signed [bale_pkg::DataW-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]              match_vec;
  bale_pkg::kind_e                  kind;
  logic                             accept, valid_idx, full_now, load_rsp;
  logic signed [bale_pkg::DataW-1:0] rd_val;
  logic [bale_pkg::StatusW-1:0]     status;

  function automatic logic full_f(logic [CNT_W-1:0] c, logic [bale_pkg::LimitW-1:0] l);
    return (CMP_W'(c) >= CMP_W'(l)) || (c >= CNT_W'(CAPACITY));
  endfunction

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    kind      = bale_pkg::kind_e'(req_i.payload.kind);
    valid_idx = CMP_W'(req_i.payload.position) < CMP_W'(count_q);
    full_now  = full_f(count_q, size_limit_q);
    cmd.op    = bale_pkg::OP_HOLD;
    cmd.look  = 1'b0;
    cmd.value = req_i.payload.value;
    wr_pos    = CNT_W'(req_i.payload.position);
    count_d   = count_q;
    rd_val    = '0;
    status    = bale_pkg::ST_OK;
    case (kind)
      bale_pkg::K_INSERT: begin
        if (!valid_idx) begin
          status = bale_pkg::ST_BAD_INDEX;
        end else if (full_now) begin
          status = bale_pkg::ST_FULL;
        end else begin
          cmd.op  = bale_pkg::OP_INSERT;
          count_d = count_q + 1'b1;
        end
      end
      bale_pkg::K_APPEND: begin
        if (full_now) begin
          status = bale_pkg::ST_FULL;
        end else begin
          cmd.op  = bale_pkg::OP_INSERT;
          wr_pos  = count_q;
          count_d = count_q + 1'b1;
        end
      end
      bale_pkg::K_CONTAINS: begin
        cmd.look = 1'b1;
      end
      bale_pkg::K_GET: begin
        if (valid_idx) begin
          rd_val = cell_data[ADDR_W'(req_i.payload.position)];
        end else begin
          rd_val = '1;
          status = bale_pkg::ST_BAD_INDEX;
        end
      end
      bale_pkg::K_REMOVE: begin
        if (valid_idx) begin
          cmd.op  = bale_pkg::OP_REMOVE;
          count_d = count_q - 1'b1;
        end else begin
          status = bale_pkg::ST_BAD_INDEX;
        end
      end
      bale_pkg::K_SET: begin
        if (valid_idx) begin
          cmd.op = bale_pkg::OP_SET;
        end else begin
          status = bale_pkg::ST_BAD_INDEX;
        end
      end
      default: begin
        status = bale_pkg::ST_OK;
      end
    endcase
    if (!accept) begin
      cmd.op   = bale_pkg::OP_HOLD;
      cmd.look = 1'b0;
      count_d  = count_q;
    end
    pend_d.read_value  = rd_val;
    // marks a search; the hit itself comes from the cells
    pend_d.found       = (kind == bale_pkg::K_CONTAINS);
    pend_d.status      = status;
    pend_d.entry_count = bale_pkg::CountW'(count_d);
    pend_d.is_empty    = (count_d == '0);
    pend_d.is_full     = full_f(count_d, size_limit_q);
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [bale_pkg::DataW-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = cell_data[i];
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    bale_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .pos_i   (wr_pos),
      .cnt_i   (count_q),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i]),
      .match_o (match_vec[i])
    );
  end

  assign load_rsp = (state_q == S_DONE) && (!rsp_valid_q || rsp_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (load_rsp) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_d       = pend_q;
    rsp_d.found = pend_q.found && (|match_vec);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      size_limit_q <= bale_pkg::LimitReset;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_i.valid && cfg_i.ready) begin
        size_limit_q <= cfg_i.payload;
      end
      if (load_rsp) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_q <= pend_d;
    end
    if (load_rsp) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

endmodule
`default_nettype wire

@@ design/bale_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bale_checker
// Port-level checks on the bounded list engine, bound to its top level.
// ----------------------------------------------------------------------------
module bale_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           req_valid_i,
  input wire logic           req_ready_i,
  input wire logic           rsp_valid_i,
  input wire logic           rsp_ready_i,
  input wire bale_pkg::rsp_t rsp_i
);

  // stalled result item holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_i))
    else $error("result item changed while stalled");

  // engine is busy in the cycle after taking an item
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("item taken while previous item in progress");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_i.is_empty == (rsp_i.entry_count == '0)))
    else $error("empty flag disagrees with count");

  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_i.found |->
      (rsp_i.status == bale_pkg::ST_OK) && (rsp_i.read_value == '0))
    else $error("search hit with bad status or read data");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_i.status == bale_pkg::ST_OK) ||
      (rsp_i.status == bale_pkg::ST_BAD_INDEX) || (rsp_i.status == bale_pkg::ST_FULL))
    else $error("undefined status code");

endmodule

bind bounded_array_list_engine bale_checker u_bale_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_i       (rsp_o.payload)
);
`default_nettype wire

@@ verif/bounded_array_list_engine_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_array_list_engine_tb
// Drives list operations and size-limit writes into the engine. A shadow copy
// of the list predicts each result, and every returned result is checked field
// by field. Covers directed corner cases, limit changes, a fill to capacity,
// output back-pressure and weighted random traffic with random idle cycles.
// ----------------------------------------------------------------------------
module bounded_array_list_engine_tb;

  localparam int unsigned Capacity      = bale_pkg::Capacity;
  localparam int unsigned IdlePct       = 6;
  localparam int unsigned RspHoldCycles = 40;
  localparam int unsigned DrainCycles   = 4;
  localparam int unsigned WatchdogLimit = 400;
  localparam int unsigned PrintLimit    = 100;

  localparam logic [bale_pkg::KindW-1:0] KindUnusedLo = 3'd6;
  localparam logic [bale_pkg::KindW-1:0] KindUnusedHi = 3'd7;

  logic clk_i;
  logic rst_ni;

  bale_chan_if #(.T(bale_pkg::req_t)) req_if ();
  bale_chan_if #(.T(bale_pkg::rsp_t)) rsp_if ();
  bale_chan_if #(.T(bale_pkg::cfg_t)) cfg_if ();

  bounded_array_list_engine dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if),
    .cfg_i (cfg_if)
  );

  // shadow list state
  logic signed [bale_pkg::DataW-1:0] list_mem [Capacity];
  logic [bale_pkg::CountW-1:0]       list_len;
  logic [bale_pkg::LimitW-1:0]       list_limit;

  bale_pkg::rsp_t expected_rsp_q [$];
  int unsigned    mismatch_cnt;
  int unsigned    req_gap_pct;
  int unsigned    rsp_gap_pct;
  bit             rsp_hold_req;
  int unsigned    stuck_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit list_at_limit();
    logic [bale_pkg::LimitW-1:0] eff;
    eff = (list_limit > Capacity) ? bale_pkg::LimitW'(Capacity) : list_limit;
    return list_len >= eff;
  endfunction

  function automatic bale_pkg::rsp_t apply_list_op(bale_pkg::req_t item);
    bale_pkg::rsp_t res;
    int unsigned    i;
    bit             in_range;
    res = '0;
    in_range = item.position < list_len;
    case (item.kind)
      bale_pkg::K_INSERT: begin
        if (!in_range) res.status = bale_pkg::ST_BAD_INDEX;
        else if (list_at_limit()) res.status = bale_pkg::ST_FULL;
        else begin
          for (i = list_len; i > item.position; i--) list_mem[i] = list_mem[i-1];
          list_mem[item.position] = item.value;
          list_len++;
        end
      end
      bale_pkg::K_APPEND: begin
        if (list_at_limit()) res.status = bale_pkg::ST_FULL;
        else begin
          list_mem[list_len] = item.value;
          list_len++;
        end
      end
      bale_pkg::K_CONTAINS: begin
        for (i = 0; i < list_len; i++)
          if (list_mem[i] == item.value) res.found = 1'b1;
      end
      bale_pkg::K_GET: begin
        if (!in_range) begin
          res.status     = bale_pkg::ST_BAD_INDEX;
          res.read_value = -1;
        end else begin
          res.read_value = list_mem[item.position];
        end
      end
      bale_pkg::K_REMOVE: begin
        if (!in_range) res.status = bale_pkg::ST_BAD_INDEX;
        else begin
          for (i = item.position; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      bale_pkg::K_SET: begin
        if (!in_range) res.status = bale_pkg::ST_BAD_INDEX;
        else list_mem[item.position] = item.value;
      end
      default: ;
    endcase
    res.entry_count = list_len;
    res.is_empty    = (list_len == 0);
    res.is_full     = list_at_limit();
    return res;
  endfunction

  function automatic logic signed [bale_pkg::DataW-1:0] pick_value();
    if (list_len != 0 && $urandom_range(0, 1) == 1)
      return list_mem[$urandom_range(0, list_len - 1)];
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -1;
      3: return 0;
      4, 5: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  function automatic void flag_field(string name, logic [bale_pkg::DataW-1:0] want,
                                     logic [bale_pkg::DataW-1:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= PrintLimit)
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
  endfunction

  // result checker
  always @(posedge clk_i) begin : result_check
    bale_pkg::rsp_t want;
    bale_pkg::rsp_t got;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.payload;
      if (expected_rsp_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= PrintLimit)
          $display("%0t: unexpected result, expected none, actual %p", $time, got);
      end else begin
        want = expected_rsp_q.pop_front();
        if (got.read_value !== want.read_value)
          flag_field("read_value", want.read_value, got.read_value);
        if (got.found !== want.found) flag_field("found", want.found, got.found);
        if (got.status !== want.status) flag_field("status", want.status, got.status);
        if (got.entry_count !== want.entry_count)
          flag_field("entry_count", want.entry_count, got.entry_count);
        if (got.is_empty !== want.is_empty)
          flag_field("is_empty", want.is_empty, got.is_empty);
        if (got.is_full !== want.is_full) flag_field("is_full", want.is_full, got.is_full);
      end
    end
  end

  // result ready with random stalls and a long hold-off on request
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rsp_hold_req) begin
        rsp_if.ready <= 1'b0;
        repeat (RspHoldCycles) @(negedge clk_i);
        rsp_hold_req = 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= rsp_gap_pct);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= WatchdogLimit) begin
        $display("bounded_array_list_engine_tb: errors");
        $finish;
      end
    end
  end

  task automatic send_op(input logic [bale_pkg::KindW-1:0] kind,
                         input logic [bale_pkg::PosW-1:0] pos,
                         input logic signed [bale_pkg::DataW-1:0] val);
    bale_pkg::req_t item;
    item.kind     = kind;
    item.position = pos;
    item.value    = val;
    while ($urandom_range(0, 99) < req_gap_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.payload <= item;
    req_if.valid   <= 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    expected_rsp_q.push_back(apply_list_op(item));
    @(negedge clk_i);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [bale_pkg::LimitW-1:0] limit);
    drain();
    cfg_if.payload <= limit;
    cfg_if.valid   <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    list_limit = limit;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_op(input int unsigned grow_pct, input int unsigned shrink_pct);
    int unsigned                 roll;
    logic [bale_pkg::KindW-1:0]  kind;
    logic [bale_pkg::PosW-1:0]   pos;
    roll = $urandom_range(0, 99);
    if (roll < grow_pct) kind = $urandom_range(0, 1) ? bale_pkg::K_APPEND : bale_pkg::K_INSERT;
    else if (roll < grow_pct + shrink_pct) kind = bale_pkg::K_REMOVE;
    else if (roll >= 96) kind = $urandom_range(0, 1) ? KindUnusedLo : KindUnusedHi;
    else begin
      case ($urandom_range(0, 2))
        0: kind = bale_pkg::K_CONTAINS;
        1: kind = bale_pkg::K_GET;
        default: kind = bale_pkg::K_SET;
      endcase
    end
    if (list_len != 0 && $urandom_range(0, 99) < 75) pos = $urandom_range(0, list_len - 1);
    else pos = $urandom_range(0, Capacity - 1);
    send_op(kind, pos, pick_value());
  endtask

  task automatic test_directed_ops();
    // empty list: every index is out of range
    send_op(bale_pkg::K_GET, 0, 0);
    send_op(bale_pkg::K_REMOVE, 0, 0);
    send_op(bale_pkg::K_INSERT, 0, 5);
    send_op(bale_pkg::K_SET, 0, 5);
    send_op(bale_pkg::K_CONTAINS, 0, 0);
    send_op(bale_pkg::K_APPEND, 63, 32'sh8000_0000);
    send_op(bale_pkg::K_APPEND, 0, 32'sh7fff_ffff);
    send_op(bale_pkg::K_INSERT, 0, -1);
    send_op(bale_pkg::K_GET, 0, 0);
    send_op(bale_pkg::K_GET, 2, 0);
    send_op(bale_pkg::K_CONTAINS, 0, 32'sh7fff_ffff);
    send_op(bale_pkg::K_SET, 1, 0);
    send_op(bale_pkg::K_GET, 63, 0);
    send_op(KindUnusedLo, 0, 0);
    send_op(KindUnusedHi, 63, -1);
    send_op(bale_pkg::K_REMOVE, 0, 0);
    send_op(bale_pkg::K_REMOVE, 1, 0);
    send_op(bale_pkg::K_CONTAINS, 0, -1);
    send_op(bale_pkg::K_GET, 0, 0);
  endtask

  task automatic test_limit_corners();
    write_limit(2);
    send_op(bale_pkg::K_APPEND, 0, 11);
    send_op(bale_pkg::K_APPEND, 0, 12);
    send_op(bale_pkg::K_INSERT, 0, 13);
    // bad index wins over full
    send_op(bale_pkg::K_INSERT, 5, 13);
    // limit below count keeps entries
    write_limit(1);
    send_op(bale_pkg::K_GET, 1, 0);
    write_limit(0);
    send_op(bale_pkg::K_REMOVE, 0, 0);
    send_op(bale_pkg::K_APPEND, 0, 14);
    write_limit(127);
  endtask

  task automatic test_fill_and_empty();
    write_limit(127);
    req_gap_pct = 0;
    rsp_gap_pct = 0;
    while (list_len < Capacity) send_op(bale_pkg::K_APPEND, $urandom_range(0, 63), pick_value());
    send_op(bale_pkg::K_APPEND, 0, 1);
    send_op(bale_pkg::K_INSERT, 0, 1);
    send_op(bale_pkg::K_GET, 63, 0);
    send_op(bale_pkg::K_CONTAINS, 0, pick_value());
    while (list_len != 0) send_op(bale_pkg::K_REMOVE, $urandom_range(0, list_len - 1), 0);
    req_gap_pct = IdlePct;
    rsp_gap_pct = IdlePct;
  endtask

  task automatic test_backpressure();
    write_limit(64);
    rsp_hold_req = 1'b1;
    repeat (16) random_op(50, 10);
    drain();
  endtask

  task automatic test_random_mix();
    logic [bale_pkg::LimitW-1:0] limits [8];
    int unsigned                 n;
    limits = '{7'd64, 7'd1, 7'd17, 7'd0, 7'd127, 7'd40, 7'd3, 7'd64};
    foreach (limits[k]) begin
      write_limit(limits[k]);
      for (n = 0; n < 110; n++) begin
        if (n == 55) drain();
        if (n < 55) random_op(55, 10);
        else random_op(15, 40);
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    list_len       = '0;
    list_limit     = bale_pkg::LimitReset;
    mismatch_cnt   = 0;
    stuck_cycles   = 0;
    rsp_hold_req   = 1'b0;
    req_gap_pct    = IdlePct;
    rsp_gap_pct    = IdlePct;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);
    test_directed_ops();
    test_limit_corners();
    test_fill_and_empty();
    test_backpressure();
    test_random_mix();
    drain();
    if (mismatch_cnt == 0 && expected_rsp_q.size() == 0) begin
      $display("bounded_array_list_engine_tb: clean");
    end else begin
      $display("bounded_array_list_engine_tb: errors");
    end
    $finish;
  end

endmodule
